[rtl/kwm_pkg.sv]
`default_nettype none
package kwm_pkg;

   // store and run geometry
   localparam int POP_DEPTH = 64;
   localparam int RUNS      = 8;
   localparam int ADDR_W    = $clog2(POP_DEPTH);
   localparam int POS_W     = $clog2(POP_DEPTH + 1);
   localparam int RUN_W     = $clog2(RUNS);

   // fixed field widths
   localparam int RUN_ID_W = 3;
   localparam int KEY_W    = 32;
   localparam int IDX_W    = 6;
   localparam int KIND_W   = 2;

   // stream packing
   localparam int REQ_DATA_W = 48;
   localparam int REQ_PAD_W  = REQ_DATA_W - RUN_ID_W - KEY_W - IDX_W;
   localparam int RSP_DATA_W = 48;
   localparam int RSP_PAD_W  = RSP_DATA_W - KEY_W - IDX_W - IDX_W;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [KIND_W-1:0] {
      KIND_CLEAR = 2'd0,
      KIND_LOAD  = 2'd1,
      KIND_PULL  = 2'd2
   } kwm_kind_type;

   typedef struct packed {
      kwm_kind_type                kind;
      logic [RUN_ID_W-1:0]         run_id;
      logic signed [KEY_W-1:0]     key;
      logic [IDX_W-1:0]            local_index;
   } kwm_item_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_EMIT
   } kwm_state_type;

   typedef struct packed {
      logic take;
      logic do_clear;
      logic do_load;
      logic do_empty;
      logic start_scan;
      logic issue;
      logic emit;
   } kwm_ctl_type;

endpackage
`default_nettype wire

[rtl/kwm_ram.sv]
`default_nettype none
module kwm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

[rtl/kwm_front.sv]
`default_nettype none
module kwm_front
   import kwm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic [KIND_W-1:0]     req_tuser,
   output logic                       q_valid,
   input  wire logic                  q_ready,
   output kwm_item_type               q_item
);

   kwm_item_type      q_mem_ff [QUEUE_DEPTH];
   kwm_item_type      q_mem_in [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              push;
   logic              pop;
   kwm_item_type      item;

   assign req_tready = (count_ff < QCNT_W'(QUEUE_DEPTH));
   assign q_valid    = (count_ff != '0);
   assign q_item     = q_mem_ff[rd_ptr_ff];
   assign pop        = q_valid && q_ready;

   // classify: unused kind codes are dropped here
   always_comb begin
      item.kind        = KIND_CLEAR;
      item.run_id      = req_tdata[RUN_ID_W-1:0];
      item.key         = req_tdata[RUN_ID_W +: KEY_W];
      item.local_index = req_tdata[RUN_ID_W+KEY_W +: IDX_W];
      push             = 1'b0;
      unique case (req_tuser)
         KIND_CLEAR: begin
            item.kind = KIND_CLEAR;
            push      = req_tvalid && req_tready;
         end
         KIND_LOAD: begin
            item.kind = KIND_LOAD;
            push      = req_tvalid && req_tready;
         end
         KIND_PULL: begin
            item.kind = KIND_PULL;
            push      = req_tvalid && req_tready;
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

   always_comb begin
      q_mem_in  = q_mem_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         q_mem_in[wr_ptr_ff] = item;
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      q_mem_ff <= q_mem_in;
   end

endmodule
`default_nettype wire

[rtl/kwm_back.sv]
`default_nettype none
module kwm_back
   import kwm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  q_valid,
   output logic                       q_ready,
   input  wire kwm_item_type          q_item,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tlast,
   output logic                       rsp_tuser
);

   kwm_state_type state_ff, state_in;
   kwm_ctl_type   ctl;

   // run records
   logic [POS_W-1:0] run_start_ff [RUNS];
   logic [POS_W-1:0] run_start_in [RUNS];
   logic [POS_W-1:0] run_end_ff   [RUNS];
   logic [POS_W-1:0] run_end_in   [RUNS];
   logic [POS_W-1:0] run_head_ff  [RUNS];
   logic [POS_W-1:0] run_head_in  [RUNS];
   logic [POS_W-1:0] fill_ff, fill_in;
   logic [POS_W-1:0] emitted_ff, emitted_in;
   logic [RUN_W-1:0] cur_run_ff, cur_run_in;

   // scan pipeline
   logic [RUN_W-1:0] cnt_ff, cnt_in;
   logic             rd_vld_ff, rd_vld_in;
   logic [RUN_W-1:0] rd_run_ff, rd_run_in;
   logic [POS_W-1:0] rd_pos_ff, rd_pos_in;
   logic [POS_W-1:0] rd_start_ff, rd_start_in;

   // best candidate
   logic                    found_ff, found_in;
   logic signed [KEY_W-1:0] best_key_ff, best_key_in;
   logic [IDX_W-1:0]        best_idx_ff, best_idx_in;
   logic [POS_W-1:0]        best_pos_ff, best_pos_in;
   logic [POS_W-1:0]        best_start_ff, best_start_in;
   logic [RUN_W-1:0]        best_run_ff, best_run_in;

   // result register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [KEY_W-1:0] rsp_key_ff, rsp_key_in;
   logic [IDX_W-1:0]        rsp_gidx_ff, rsp_gidx_in;
   logic [IDX_W-1:0]        rsp_src_ff, rsp_src_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic                    rsp_empty_ff, rsp_empty_in;

   // store ports
   logic                    load_ok;
   logic                    ram_we;
   logic [ADDR_W-1:0]       ram_rd_addr;
   logic signed [KEY_W-1:0] key_rd;
   logic [IDX_W-1:0]        idx_rd;
   logic                    store_empty;

   assign store_empty = (fill_ff == emitted_ff);
   assign load_ok = (int'(q_item.run_id) < RUNS)
                 && (q_item.run_id >= RUN_ID_W'(cur_run_ff))
                 && (fill_ff < POS_W'(POP_DEPTH));
   assign ram_we      = ctl.do_load && load_ok;
   assign ram_rd_addr = run_head_ff[cnt_ff][ADDR_W-1:0];

   kwm_ram #(.WIDTH(KEY_W), .DEPTH(POP_DEPTH)) u_key_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (fill_ff[ADDR_W-1:0]),
      .wr_data (q_item.key),
      .rd_addr (ram_rd_addr),
      .rd_data (key_rd)
   );

   kwm_ram #(.WIDTH(IDX_W), .DEPTH(POP_DEPTH)) u_index_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (fill_ff[ADDR_W-1:0]),
      .wr_data (q_item.local_index),
      .rd_addr (ram_rd_addr),
      .rd_data (idx_rd)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (ctl.start_scan) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cnt_ff == RUN_W'(RUNS - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_EMIT;
         ST_EMIT:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      ctl = '0;
      unique case (state_ff)
         ST_IDLE: begin
            ctl.take       = q_valid && ((q_item.kind != KIND_PULL) || !rsp_valid_ff);
            ctl.do_clear   = ctl.take && (q_item.kind == KIND_CLEAR);
            ctl.do_load    = ctl.take && (q_item.kind == KIND_LOAD);
            ctl.do_empty   = ctl.take && (q_item.kind == KIND_PULL) && store_empty;
            ctl.start_scan = ctl.take && (q_item.kind == KIND_PULL) && !store_empty;
         end
         ST_SCAN:  ctl.issue = 1'b1;
         ST_DRAIN: ctl.issue = 1'b0;
         ST_EMIT:  ctl.emit  = 1'b1;
         default:  ctl = '0;
      endcase
   end

   assign q_ready = ctl.take;

   // datapath
   always_comb begin
      run_start_in  = run_start_ff;
      run_end_in    = run_end_ff;
      run_head_in   = run_head_ff;
      fill_in       = fill_ff;
      emitted_in    = emitted_ff;
      cur_run_in    = cur_run_ff;
      cnt_in        = cnt_ff;
      rd_vld_in     = 1'b0;
      rd_run_in     = cnt_ff;
      rd_pos_in     = run_head_ff[cnt_ff];
      rd_start_in   = run_start_ff[cnt_ff];
      found_in      = found_ff;
      best_key_in   = best_key_ff;
      best_idx_in   = best_idx_ff;
      best_pos_in   = best_pos_ff;
      best_start_in = best_start_ff;
      best_run_in   = best_run_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_gidx_in   = rsp_gidx_ff;
      rsp_src_in    = rsp_src_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_empty_in  = rsp_empty_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (ctl.do_clear) begin
         for (int r = 0; r < RUNS; r++) begin
            run_start_in[r] = '0;
            run_end_in[r]   = '0;
            run_head_in[r]  = '0;
         end
         fill_in    = '0;
         emitted_in = '0;
         cur_run_in = '0;
      end

      if (ram_we) begin
         // runs passed over get an empty range at the fill position
         for (int r = 0; r < RUNS; r++) begin
            if ((r > int'(cur_run_ff)) && (r <= int'(q_item.run_id))) begin
               run_start_in[r] = fill_ff;
               run_end_in[r]   = fill_ff;
               run_head_in[r]  = fill_ff;
            end
         end
         run_end_in[q_item.run_id[RUN_W-1:0]] = fill_ff + 1'b1;
         fill_in    = fill_ff + 1'b1;
         cur_run_in = q_item.run_id[RUN_W-1:0];
      end

      if (ctl.do_empty) begin
         rsp_valid_in = 1'b1;
         rsp_key_in   = '0;
         rsp_gidx_in  = '0;
         rsp_src_in   = '0;
         rsp_last_in  = 1'b0;
         rsp_empty_in = 1'b1;
      end

      if (ctl.start_scan) begin
         cnt_in   = '0;
         found_in = 1'b0;
      end

      if (ctl.issue) begin
         rd_vld_in = (run_head_ff[cnt_ff] < run_end_ff[cnt_ff]);
         cnt_in    = (cnt_ff == RUN_W'(RUNS - 1)) ? '0 : cnt_ff + 1'b1;
      end

      // strict less keeps the lower run on ties
      if (rd_vld_ff && (!found_ff || (key_rd < best_key_ff))) begin
         found_in      = 1'b1;
         best_key_in   = key_rd;
         best_idx_in   = idx_rd;
         best_pos_in   = rd_pos_ff;
         best_start_in = rd_start_ff;
         best_run_in   = rd_run_ff;
      end

      if (ctl.emit) begin
         run_head_in[best_run_ff] = best_pos_ff + 1'b1;
         emitted_in   = emitted_ff + 1'b1;
         rsp_valid_in = 1'b1;
         rsp_key_in   = best_key_ff;
         rsp_gidx_in  = best_idx_ff + best_start_ff[IDX_W-1:0];
         rsp_src_in   = best_pos_ff[IDX_W-1:0];
         rsp_last_in  = ((fill_ff - emitted_ff) == POS_W'(1));
         rsp_empty_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         run_start_ff <= '{default: '0};
         run_end_ff   <= '{default: '0};
         run_head_ff  <= '{default: '0};
         fill_ff      <= '0;
         emitted_ff   <= '0;
         cur_run_ff   <= '0;
         rd_vld_ff    <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         run_start_ff <= run_start_in;
         run_end_ff   <= run_end_in;
         run_head_ff  <= run_head_in;
         fill_ff      <= fill_in;
         emitted_ff   <= emitted_in;
         cur_run_ff   <= cur_run_in;
         rd_vld_ff    <= rd_vld_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff        <= cnt_in;
      rd_run_ff     <= rd_run_in;
      rd_pos_ff     <= rd_pos_in;
      rd_start_ff   <= rd_start_in;
      best_key_ff   <= best_key_in;
      best_idx_ff   <= best_idx_in;
      best_pos_ff   <= best_pos_in;
      best_start_ff <= best_start_in;
      best_run_ff   <= best_run_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_gidx_ff   <= rsp_gidx_in;
      rsp_src_ff    <= rsp_src_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_src_ff, rsp_gidx_ff, rsp_key_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_empty_ff;

endmodule
`default_nettype wire

[rtl/k_way_merge_of_sorted_runs.sv]
// k-way merge of up to RUNS ascending-sorted runs held in a 64-entry store. Each request
// transaction is a clear (empties the store), a load (appends a signed Q16.16 key and its
// run-local index; loads must arrive in nondecreasing run order, and a load into a lower run
// or into a full store is dropped) or a pull. Clear and load give no response; every pull
// gives exactly one response transaction carrying the smallest remaining head key, its global
// index (local index plus run start, modulo 64) and its store position, with tlast marking
// the final element; once the store is exhausted a pull returns tuser high with zero data.
// Equal keys go to the lowest run. Timing: requests enter a two-entry queue, so the request
// side can take up to two transactions while the merge engine works or a response waits. In
// the engine, a clear, a load or a pull on an empty store is done when it is taken from the
// queue; a pull on a nonempty store is taken, then each run's head is read in turn from the
// single read port of the key store, the last read returns, and the result is committed. A
// pull waits in the queue until the previous response has been taken. No clearing pass is
// needed after reset: store entries are read only below a run end, so they are always
// written first.
`default_nettype none
module k_way_merge_of_sorted_runs
   import kwm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // run_id[2:0], key[34:3], local_index[40:35]
   input  wire logic [KIND_W-1:0]     req_tuser,   // kind[1:0]
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,   // out_key[31:0], global_index[37:32],
                                                   // source_position[43:38]
   output logic                       rsp_tlast,   // is_last
   output logic                       rsp_tuser    // empty_res
);

   // decoded items between the front queue and the merge engine
   logic         q_valid;
   logic         q_ready;
   kwm_item_type q_item;

   // front: decode kind, drop unused codes, queue the transaction
   kwm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_item     (q_item)
   );

   // back: run records, key store, head scan and response register
   kwm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_item     (q_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
`default_nettype wire

[rtl/kwm_checker.sv]
`default_nettype none
module kwm_checker
   import kwm_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic [REQ_DATA_W-1:0] req_tdata,
   input wire logic [KIND_W-1:0]     req_tuser,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                  rsp_tlast,
   input wire logic                  rsp_tuser
);

   // an empty response carries no element
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> (rsp_tdata == '0) && !rsp_tlast)
      else $error("empty response with nonzero payload");

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // no response right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // a pull is taken only once no response is waiting, so valid drops in the cycle after a response transaction
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready |=> !rsp_tvalid)
      else $error("response valid right after a response transaction");

endmodule

bind k_way_merge_of_sorted_runs kwm_checker u_kwm_checker (.*);
`default_nettype wire
